// ----- hdl/ptw_pkg.sv -----
`default_nettype none

package ptw_pkg;

  // Virtual address split: four 9-bit indices over a 4 KiB page offset
  localparam int IDX_W  = 9;
  localparam int PAGE_W = 12;
  localparam int HUGE_W = 21;
  localparam int PFN_W  = 40;
  localparam int VA_W   = 48;
  localparam int PA_W   = 52;
  localparam int ENT_W  = 64;

  // Entry flag bits
  localparam int PTE_P_BIT = 0;
  localparam int PTE_W_BIT = 1;
  localparam int PTE_H_BIT = 7;

  // Request kinds
  localparam logic [1:0] REQ_XLATE = 2'd0;
  localparam logic [1:0] REQ_MAP   = 2'd1;
  localparam logic [1:0] REQ_UNMAP = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOTPRES = 2'd1;
  localparam logic [1:0] ST_HUGE    = 2'd2;
  localparam logic [1:0] ST_NOFRAME = 2'd3;

  // Configuration register indexes
  localparam int         CFG_IDX_W    = 1;
  localparam logic [0:0] CFG_IDENTITY = 1'b0;
  localparam logic [0:0] CFG_BASE     = 1'b1;

  localparam logic [PFN_W-1:0] BASE_RESET = 40'd256;

  // Decoded view of one table entry
  typedef struct packed {
    logic present;
    logic huge;
    logic in_range;
  } entry_info_t;

endpackage

`default_nettype wire

// ----- hdl/ptw_store.sv -----
`default_nettype none

// Table frame store: one write port, one read port, registered read data
module ptw_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [ptw_pkg::ENT_W-1:0]   wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [ptw_pkg::ENT_W-1:0]   rd_data
);

  logic [ptw_pkg::ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ptw_entry_unit.sv -----
`default_nettype none

// Entry decoder: flag bits and store frame of a pointer entry
module ptw_entry_unit #(
  parameter int TABLE_FRAMES = 16
) (
  input  wire logic [ptw_pkg::ENT_W-1:0]  entry,
  input  wire logic [ptw_pkg::PFN_W-1:0]  base,
  output ptw_pkg::entry_info_t            info,
  output logic [$clog2(TABLE_FRAMES)-1:0] frame
);

  localparam int FW = $clog2(TABLE_FRAMES);

  logic [ptw_pkg::PFN_W-1:0] offset;

  // frame offset from the table base, wrapping at 40 bits
  assign offset = entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_W] - base;

  assign info.present  = entry[ptw_pkg::PTE_P_BIT];
  assign info.huge     = entry[ptw_pkg::PTE_H_BIT];
  assign info.in_range = offset < ptw_pkg::PFN_W'(TABLE_FRAMES);
  assign frame         = offset[FW-1:0];

endmodule

`default_nettype wire

// ----- hdl/page_table_walk_map_unmap.sv -----
// A translate passes through a store read state and an evaluate state for each
// table level; a map or unmap on existing tables reads three levels, then writes
// the leaf. Identity-region requests and request kind 3 skip the store entirely.
// Each table created by a map adds a 512-entry frame clear and a link write.
// One request at a time. Reset is synchronous; afterwards a clearing pass over all
// TABLE_FRAMES*512 entries zeroes the store; no input beat is taken until it ends.
`default_nettype none

module page_table_walk_map_unmap #(
  parameter int TABLE_FRAMES        = 16,
  parameter int IDENTITY_ROOT_SLOTS = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ptw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ptw_pkg::PFN_W-1:0]      cfg_data,
  // request stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [111:0]                   s_axis_tdata,  // virt_addr, phys_addr, flags
  input  wire logic [1:0]                     s_axis_tuser,  // req_type
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [55:0]                         m_axis_tdata,  // phys_result, zero pad
  output logic [2:0]                          m_axis_tuser   // status, tlb_invalidate
);

  localparam int FW    = $clog2(TABLE_FRAMES);
  localparam int NW    = $clog2(TABLE_FRAMES + 1);
  localparam int IW    = ptw_pkg::IDX_W;
  localparam int AW    = FW + IW;
  localparam int DEPTH = TABLE_FRAMES * 512;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_CLRF = 3'd4;
  localparam logic [2:0] S_PAR  = 3'd5;
  localparam logic [2:0] S_LEAF = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                   state;
  logic [AW-1:0]                clr_ctr;
  logic [NW-1:0]                next_free;
  logic                         id_en;
  logic [ptw_pkg::PFN_W-1:0]    base;

  logic [1:0]                   req_type;
  logic [ptw_pkg::VA_W-1:0]     virt;
  logic [ptw_pkg::PA_W-1:0]     phys;
  logic [ptw_pkg::PAGE_W-1:0]   flags;
  logic [1:0]                   lvl;
  logic [FW-1:0]                frame;
  logic [ptw_pkg::PA_W-1:0]     res;
  logic [1:0]                   st;
  logic                         tlb;

  logic [ptw_pkg::PA_W-1:0]     out_res;
  logic [1:0]                   out_st;
  logic                         out_tlb;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [ptw_pkg::ENT_W-1:0]    wr_data;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [ptw_pkg::ENT_W-1:0]    rd_data;

  ptw_pkg::entry_info_t         info;
  logic [FW-1:0]                ent_frame;

  logic [IW-1:0]                idx_sel;
  logic [FW-1:0]                nf_frame;
  logic                         no_frame;
  logic [ptw_pkg::PFN_W-1:0]    new_pfn;
  logic [IW-1:0]                in_i4;
  logic                         in_ident;
  logic                         is_map;
  logic                         in_beat;

  // request fields straight off the input beat
  assign in_i4    = s_axis_tdata[47:39];
  assign in_ident = id_en &&
                    ({1'b0, in_i4} < (IW + 1)'(IDENTITY_ROOT_SLOTS));
  assign in_beat  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  assign is_map   = (req_type == ptw_pkg::REQ_MAP);
  assign nf_frame = next_free[FW-1:0];
  assign no_frame = next_free >= NW'(TABLE_FRAMES);
  assign new_pfn  = base + ptw_pkg::PFN_W'(next_free);

  // table index for the current level
  always_comb begin
    case (lvl)
      2'd0:    idx_sel = virt[47:39];
      2'd1:    idx_sel = virt[38:30];
      2'd2:    idx_sel = virt[29:21];
      default: idx_sel = virt[20:12];
    endcase
  end

  // store port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {frame, idx_sel};
    wr_data = '0;
    case (state)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_ctr;
      end
      S_CLRF: begin
        wr_en   = 1'b1;
        wr_addr = {nf_frame, clr_ctr[IW-1:0]};
      end
      S_PAR: begin
        wr_en   = 1'b1;
        wr_data = {12'h000, new_pfn, 12'h003};
      end
      S_LEAF: begin
        wr_en = 1'b1;
        if (is_map) begin
          wr_data = {12'h000, phys[ptw_pkg::PA_W-1:ptw_pkg::PAGE_W],
                     flags | 12'h001};
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_en   = (state == S_RD);
  assign rd_addr = {frame, idx_sel};

  ptw_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ptw_entry_unit #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_entry (
    .entry (rd_data),
    .base  (base),
    .info  (info),
    .frame (ent_frame)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      id_en <= 1'b1;
      base  <= ptw_pkg::BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptw_pkg::CFG_IDENTITY: id_en <= cfg_data[0];
        ptw_pkg::CFG_BASE:     base  <= cfg_data;
        default:               id_en <= id_en;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_type <= s_axis_tuser;
      virt     <= s_axis_tdata[47:0];
      phys     <= s_axis_tdata[99:48];
      flags    <= s_axis_tdata[111:100];
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_ctr   <= '0;
      next_free <= NW'(1);
      lvl       <= '0;
      frame     <= '0;
      res       <= '0;
      st        <= ptw_pkg::ST_OK;
      tlb       <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_ctr <= clr_ctr + AW'(1);
          if (clr_ctr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            tlb   <= 1'b0;
            lvl   <= 2'd0;
            frame <= '0;
            if (s_axis_tuser == ptw_pkg::REQ_NONE) begin
              res   <= '0;
              st    <= ptw_pkg::ST_OK;
              state <= S_DONE;
            end else if (in_ident) begin
              if (s_axis_tuser == ptw_pkg::REQ_XLATE) begin
                res <= {4'h0, s_axis_tdata[47:0]};
                st  <= ptw_pkg::ST_OK;
              end else begin
                res <= '0;
                st  <= ptw_pkg::ST_HUGE;
              end
              state <= S_DONE;
            end else begin
              res   <= '0;
              st    <= ptw_pkg::ST_OK;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (lvl == 2'd3) begin
            // leaf of a translate
            if (info.present) begin
              res <= {rd_data[51:12], virt[11:0]};
            end else begin
              st <= ptw_pkg::ST_NOTPRES;
            end
            state <= S_DONE;
          end else if (lvl == 2'd2 && info.huge &&
                       (is_map || info.present)) begin
            // huge page directory entry
            if (req_type == ptw_pkg::REQ_XLATE) begin
              res <= {rd_data[51:21], virt[20:0]};
            end else begin
              st <= ptw_pkg::ST_HUGE;
            end
            state <= S_DONE;
          end else if (!info.present) begin
            if (!is_map) begin
              st    <= ptw_pkg::ST_NOTPRES;
              state <= S_DONE;
            end else if (no_frame) begin
              st    <= ptw_pkg::ST_NOFRAME;
              state <= S_DONE;
            end else begin
              clr_ctr <= '0;
              state   <= S_CLRF;
            end
          end else if (!info.in_range) begin
            st    <= ptw_pkg::ST_NOTPRES;
            state <= S_DONE;
          end else begin
            frame <= ent_frame;
            lvl   <= lvl + 2'd1;
            if (lvl == 2'd2 && req_type != ptw_pkg::REQ_XLATE) begin
              state <= S_LEAF;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_CLRF: begin
          clr_ctr <= clr_ctr + AW'(1);
          if (clr_ctr[IW-1:0] == {IW{1'b1}}) begin
            state <= S_PAR;
          end
        end
        S_PAR: begin
          // link the fresh table and step into it
          frame     <= nf_frame;
          next_free <= next_free + NW'(1);
          lvl       <= lvl + 2'd1;
          state     <= (lvl == 2'd2) ? S_LEAF : S_RD;
        end
        S_LEAF: begin
          tlb   <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      out_res <= res;
      out_st  <= st;
      out_tlb <= tlb;
    end
  end

  assign m_axis_tdata = {4'h0, out_res};
  assign m_axis_tuser = {out_tlb, out_st};

endmodule

`default_nettype wire

// ----- hdl/ptw_checker.sv -----
`default_nettype none

module ptw_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [55:0]  m_axis_tdata,
  input wire logic [2:0]   m_axis_tuser
);

  // stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one request in flight: busy right after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a walk is running");

  // an invalidate (leaf write) comes only with a clean status and a zero address
  a_tlb: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tuser[1:0] == ptw_pkg::ST_OK && m_axis_tdata == 56'd0)
    else $error("invalidate with failure status or address");

  // a translated address comes only with a clean status
  a_res: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata != 56'd0 |->
      m_axis_tuser[1:0] == ptw_pkg::ST_OK && !m_axis_tuser[2])
    else $error("address returned with error status");

endmodule

bind page_table_walk_map_unmap ptw_checker u_ptw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
